// File: src/normalized_autocorrelation_assert.svh
// ---------------------------------------------------------------------------
// normalized_autocorrelation_assert.svh
// Assertion macros for the normalized autocorrelation top-level module.
// ---------------------------------------------------------------------------
`ifndef NORMALIZED_AUTOCORRELATION_ASSERT_SVH
`define NORMALIZED_AUTOCORRELATION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nac: same-cycle check failed");

// Next-cycle implication.
`define NAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nac: next-cycle check failed");

`endif

// File: src/nac_pkg.sv
// ---------------------------------------------------------------------------
// nac_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package nac_pkg;

  localparam int MAX_SAMPLES_DEF  = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORR_W           = 16;  // Q1.15 result width
  localparam int QUOT_BITS        = 16;  // quotient bits before rounding
  localparam int STEP_W           = $clog2(QUOT_BITS);

  localparam logic [CORR_W-1:0] CORR_POS_MAX = 16'h7FFF;
  localparam logic [CORR_W-1:0] CORR_NEG_MAX = 16'h8000;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // store the accepted sample
    logic clr_acc;     // clear the lag accumulator
    logic issue;       // read a sample pair into the product pipe
    logic latch_norm;  // lag 0: accumulator becomes the norm
    logic div_start;   // load the divider
    logic div_step;    // one restoring-division step
    logic out_load;    // load the output register
    logic out_last;    // result is the final lag
    logic block_done;  // clear count and sum
  } nac_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } nac_stat_t;

endpackage

// File: src/normalized_autocorrelation.sv
// ---------------------------------------------------------------------------
// normalized_autocorrelation
// Block autocorrelation normalized by the deviation square sum, Q1.15 out.
// ---------------------------------------------------------------------------
// Samples stream in one beat per cycle; tlast closes a block of N samples
// (at most MAX_SAMPLES; samples past a full store are dropped). After the
// closing beat the block emits N results, lag 0 first, each the sum of
// d(i)*d(i+k) over the sum of d(i)^2 with d = N*x - sum, rounded to Q1.15 and
// saturated (lag 0 gives 32767). A flat block gives 0 with zero_variance set
// on every result. Timing: loading is one sample per cycle. Each lag k
// passes its N-k sample pairs through the two-port sample store and the
// multiply pipe, drains that pipe, runs the bit-serial divider and then
// hands off the result, which an output stall can hold back. Input is held
// off (s_tready low) until the final lag has been handed off.
// ---------------------------------------------------------------------------
module normalized_autocorrelation #(
  parameter int MAX_SAMPLES  = nac_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = nac_pkg::SAMPLE_WIDTH_DEF,
  parameter int IW   = $clog2(MAX_SAMPLES),
  parameter int INW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int OUTW = ((IW + nac_pkg::CORR_W + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [INW-1:0]  s_tdata,   // sample
  input  logic            s_tlast,   // last_sample
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OUTW-1:0] m_tdata,   // lag, correlation
  output logic            m_tuser,   // zero_variance
  output logic            m_tlast    // last_lag
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  nac_pkg::nac_cmd_t            cmd;
  nac_pkg::nac_stat_t           stat;
  logic [CW-1:0]                count;
  logic [IW-1:0]                addr0, addr1, lag, out_lag;
  logic [nac_pkg::CORR_W-1:0]   out_corr;

  nac_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .IW(IW), .CW(CW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .count    (count),
    .stat     (stat),
    .cmd      (cmd),
    .addr0    (addr0),
    .addr1    (addr1),
    .lag      (lag)
  );

  nac_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH), .IW(IW), .CW(CW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
    .addr0     (addr0),
    .addr1     (addr1),
    .lag       (lag),
    .count     (count),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_lag   (out_lag),
    .out_corr  (out_corr),
    .out_zero  (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = OUTW'({out_corr, out_lag});

`include "normalized_autocorrelation_assert.svh"

  // no sample reads are issued while the input side is open
  `NAC_ASSERT_NOW(a_no_issue_in_load, cmd.issue, !s_tready)
  // a pending result is never overwritten
  `NAC_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_tvalid)
  // the block is closed only together with its final lag
  `NAC_ASSERT_NOW(a_done_on_last, cmd.block_done, cmd.out_load && cmd.out_last)
  // after a block closes the count is back at zero
  `NAC_ASSERT_NEXT(a_count_cleared, cmd.block_done, count == '0)

endmodule

// File: src/nac_ctrl.sv
// ---------------------------------------------------------------------------
// nac_ctrl
// Sequencer: sample load, per-lag product pass, division, result hand-off.
// ---------------------------------------------------------------------------
module nac_ctrl #(
  parameter int MAX_SAMPLES = nac_pkg::MAX_SAMPLES_DEF,
  parameter int IW = $clog2(MAX_SAMPLES),
  parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  logic [CW-1:0]     count,
  input  nac_pkg::nac_stat_t stat,
  output nac_pkg::nac_cmd_t  cmd,
  output logic [IW-1:0]     addr0,
  output logic [IW-1:0]     addr1,
  output logic [IW-1:0]     lag
);

  typedef enum logic [2:0] {LOAD, ACC, DRAIN, DIV, EMIT} state_t;

  state_t                      state;
  logic [IW-1:0]               i, k;
  logic [nac_pkg::STEP_W-1:0]  step;
  logic                        pass_end, lag_last;

  assign pass_end = (CW'(i) == count - CW'(1) - CW'(k));
  assign lag_last = (CW'(k) == count - CW'(1));
  assign in_ready = (state == LOAD);
  assign addr0    = i;
  assign addr1    = i + k;
  assign lag      = k;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == LOAD) && in_valid;
    cmd.clr_acc    = ((state == LOAD) && in_valid && in_last) ||
                     ((state == EMIT) && !stat.out_busy && !lag_last);
    cmd.issue      = (state == ACC);
    cmd.div_start  = (state == DRAIN) && !stat.pipe_busy;
    cmd.latch_norm = cmd.div_start && (k == '0);
    cmd.div_step   = (state == DIV);
    cmd.out_load   = (state == EMIT) && !stat.out_busy;
    cmd.out_last   = lag_last;
    cmd.block_done = cmd.out_load && lag_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      i     <= '0;
      k     <= '0;
      step  <= '0;
    end else begin
      case (state)
        LOAD: begin
          if (in_valid && in_last) begin
            i     <= '0;
            k     <= '0;
            state <= ACC;
          end
        end
        ACC: begin
          if (pass_end) state <= DRAIN;
          else i <= i + IW'(1);
        end
        DRAIN: begin
          if (!stat.pipe_busy) begin
            step  <= '0;
            state <= DIV;
          end
        end
        DIV: begin
          step <= step + nac_pkg::STEP_W'(1);
          if (step == nac_pkg::STEP_W'(nac_pkg::QUOT_BITS - 1)) state <= EMIT;
        end
        EMIT: begin
          if (!stat.out_busy) begin
            if (lag_last) begin
              state <= LOAD;
            end else begin
              k     <= k + IW'(1);
              i     <= '0;
              state <= ACC;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

endmodule

// File: src/nac_dp.sv
// ---------------------------------------------------------------------------
// nac_dp
// Sample store, deviation/product pipe, accumulator, serial divider, output.
// ---------------------------------------------------------------------------
module nac_dp #(
  parameter int MAX_SAMPLES  = nac_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = nac_pkg::SAMPLE_WIDTH_DEF,
  parameter int IW = $clog2(MAX_SAMPLES),
  parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nac_pkg::nac_cmd_t             cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [IW-1:0]                 addr0,
  input  logic [IW-1:0]                 addr1,
  input  logic [IW-1:0]                 lag,
  output logic [CW-1:0]                 count,
  output nac_pkg::nac_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [IW-1:0]                 out_lag,
  output logic [nac_pkg::CORR_W-1:0]    out_corr,
  output logic                          out_zero,
  output logic                          out_last
);

  localparam int SUMW = SAMPLE_WIDTH + CW;
  localparam int DW   = SAMPLE_WIDTH + CW + 2;   // N*x - S
  localparam int PW   = 2 * DW;
  localparam int AW   = PW + CW;
  localparam int QB   = nac_pkg::QUOT_BITS;
  localparam int OW   = nac_pkg::CORR_W;

  logic signed [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_WIDTH-1:0] x0, x1;
  logic signed [SUMW-1:0]         sum;
  logic signed [DW-1:0]           d0, d1, d0_next, d1_next;
  logic signed [PW-1:0]           p;
  logic signed [AW-1:0]           acc;
  logic [AW-1:0]                  norm, rem, den;
  logic [AW-1:0]                  mag_v, den_v;
  logic [AW:0]                    rem2;
  logic [QB-1:0]                  q;
  logic                           neg, sat, zero;
  logic                           v1, v2, v3;
  logic [QB:0]                    qr;
  logic [OW-1:0]                  corr_v;
  logic signed [CW:0]             n_s;

  // ---- sample store and running sum ----
  always_ff @(posedge clk) begin
    if (cmd.load && (count < CW'(MAX_SAMPLES))) mem[count[IW-1:0]] <= sample;
    x0 <= mem[addr0];
    x1 <= mem[addr1];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.block_done) begin
      count <= '0;
      sum   <= '0;
    end else if (cmd.load && (count < CW'(MAX_SAMPLES))) begin
      count <= count + CW'(1);
      sum   <= sum + SUMW'(sample);
    end
  end

  // ---- deviation and product pipe ----
  // operands widened to DW before the multiply so N*x never wraps
  assign n_s     = $signed({1'b0, count});
  assign d0_next = DW'(n_s) * DW'(x0) - DW'(sum);
  assign d1_next = DW'(n_s) * DW'(x1) - DW'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d0 <= d0_next;
    d1 <= d1_next;
    p  <= d0 * d1;
    if (cmd.clr_acc) acc <= '0;
    else if (v3)     acc <= acc + AW'(p);
  end

  assign stat.pipe_busy = v1 | v2 | v3;

  // ---- restoring divider, one quotient bit per step ----
  assign mag_v = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign den_v = cmd.latch_norm ? AW'(acc) : norm;
  assign rem2  = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.latch_norm) norm <= AW'(acc);
    if (cmd.div_start) begin
      rem  <= mag_v;
      den  <= den_v;
      neg  <= acc[AW-1];
      zero <= (den_v == '0);
      sat  <= (mag_v >= den_v);
      q    <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= AW'(rem2 - {1'b0, den});
        q   <= {q[QB-2:0], 1'b1};
      end else begin
        rem <= AW'(rem2);
        q   <= {q[QB-2:0], 1'b0};
      end
    end
  end

  // round half away from zero, then saturate
  assign qr = ({1'b0, q} + (QB+1)'(1)) >> 1;

  always_comb begin
    if (zero)     corr_v = '0;
    else if (sat) corr_v = neg ? nac_pkg::CORR_NEG_MAX : nac_pkg::CORR_POS_MAX;
    else if (neg) corr_v = (qr >= (QB+1)'(nac_pkg::CORR_NEG_MAX)) ? nac_pkg::CORR_NEG_MAX
                                                                 : OW'(-qr);
    else          corr_v = (qr > (QB+1)'(nac_pkg::CORR_POS_MAX)) ? nac_pkg::CORR_POS_MAX
                                                                : OW'(qr);
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lag  <= lag;
      out_corr <= corr_v;
      out_zero <= zero;
      out_last <= cmd.out_last;
    end
  end

  assign stat.out_busy = out_valid;

endmodule
